/* rtl/dnle_pkg.sv */
// dnle_pkg: shared types and constants of the name label encoder
// used by dnle_name_state, dnle_result_seq and dns_name_label_encoder
package dnle_pkg;

    localparam int unsigned OFS_W = 9;                  // packet offset width
    localparam logic [OFS_W-1:0] HEADER_BYTES = 9'd12;  // fixed header ahead of the name
    localparam logic [OFS_W-1:0] MAX_NAME     = 9'd255; // longest name accepted
    localparam logic [7:0] DOT_CHAR  = 8'd46;
    localparam logic [7:0] END_CHAR  = 8'd0;
    localparam logic [7:0] MAX_LABEL = 8'd63;

    // configuration register indexes
    localparam logic CFG_QUERY_TYPE  = 1'b0;
    localparam logic CFG_QUERY_CLASS = 1'b1;

    // results of a terminator, in output order
    typedef enum logic [2:0] {
        STEP_LEN,
        STEP_ZERO,
        STEP_TYPE_HI,
        STEP_TYPE_LO,
        STEP_CLASS_HI,
        STEP_CLASS_LO
    } t_step;

    // first result of an accepted character, handed to the result sequencer
    typedef struct packed {
        logic             drop;     // no result at all
        logic             term;     // terminator, five more results follow
        logic [OFS_W-1:0] offset;
        logic [7:0]       value;
        logic             err;
        logic [OFS_W-1:0] end_ofs;  // header + name length
    } t_first;

endpackage

/* rtl/dnle_name_state.sv */
// dnle_name_state: position, label and error tracking of the current name
// depends on dnle_pkg
module dnle_name_state
    import dnle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    output t_first     o_first
);

    logic [7:0] r_pos, n_pos;
    logic [7:0] r_start, n_start;
    logic [7:0] r_len, n_len;
    logic       r_err, n_err;

    logic [OFS_W-1:0] pos_ofs;
    logic [OFS_W-1:0] start_ofs;
    logic [7:0]       len_inc;

    assign pos_ofs   = {1'b0, r_pos} + HEADER_BYTES;
    assign start_ofs = {1'b0, r_start} + HEADER_BYTES;
    assign len_inc   = (r_len == 8'hFF) ? r_len : r_len + 8'd1;

    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_err   = r_err;
        o_first = '0;
        o_first.end_ofs = pos_ofs;
        if (i_char == END_CHAR) begin
            o_first.term   = 1'b1;
            o_first.offset = start_ofs;
            o_first.value  = r_len;
            o_first.err    = r_err;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
            n_err   = 1'b0;
        end else if ({1'b0, r_pos} >= MAX_NAME) begin
            // name full: character dropped
            o_first.drop = 1'b1;
            n_err = 1'b1;
        end else if (i_char == DOT_CHAR) begin
            o_first.offset = start_ofs;
            o_first.value  = r_len;
            o_first.err    = r_err;
            n_start = r_pos + 8'd1;
            n_len   = '0;
            n_pos   = r_pos + 8'd1;
        end else begin
            n_len = len_inc;
            n_err = r_err | (len_inc > MAX_LABEL);
            o_first.offset = pos_ofs + 9'd1;
            o_first.value  = i_char;
            o_first.err    = n_err;
            n_pos = r_pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

endmodule

/* rtl/dnle_result_seq.sv */
// dnle_result_seq: output register and terminator write sequence
// depends on dnle_pkg
module dnle_result_seq
    import dnle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_first           i_first,
    input  logic [15:0]      i_query_type,
    input  logic [15:0]      i_query_class,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_free,
    output logic [OFS_W-1:0] o_offset,
    output logic [7:0]       o_value,
    output logic             o_last,
    output logic [OFS_W-1:0] o_pkt,
    output logic             o_err
);

    logic             r_valid, n_valid;
    t_step            r_step, n_step;
    logic [OFS_W-1:0] r_end, n_end;
    logic [OFS_W-1:0] r_offset, n_offset;
    logic [7:0]       r_value, n_value;
    logic             r_last, n_last;
    logic [OFS_W-1:0] r_pkt, n_pkt;
    logic             r_err, n_err;

    logic xfer;
    t_step step_inc;

    assign xfer     = r_valid & i_out_ready;
    assign o_free   = !r_valid || (i_out_ready && r_last);
    assign step_inc = t_step'(r_step + 3'd1);

    always_comb begin
        n_valid  = r_valid;
        n_step   = r_step;
        n_end    = r_end;
        n_offset = r_offset;
        n_value  = r_value;
        n_last   = r_last;
        n_pkt    = r_pkt;
        n_err    = r_err;
        if (i_load && !i_first.drop) begin
            n_valid  = 1'b1;
            n_step   = STEP_LEN;
            n_end    = i_first.end_ofs;
            n_offset = i_first.offset;
            n_value  = i_first.value;
            n_last   = !i_first.term;
            n_pkt    = '0;
            n_err    = i_first.err;
        end else if (xfer && r_last) begin
            n_valid = 1'b0;
        end else if (xfer) begin
            n_step   = step_inc;
            n_offset = r_end + {6'd0, step_inc};
            n_last   = (step_inc == STEP_CLASS_LO);
            n_pkt    = (step_inc == STEP_CLASS_LO) ? r_end + 9'd6 : '0;
            case (step_inc)
                STEP_ZERO:     n_value = 8'd0;
                STEP_TYPE_HI:  n_value = i_query_type[15:8];
                STEP_TYPE_LO:  n_value = i_query_type[7:0];
                STEP_CLASS_HI: n_value = i_query_class[15:8];
                STEP_CLASS_LO: n_value = i_query_class[7:0];
                default:       n_value = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_LEN;
            r_last  <= 1'b1;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end    <= n_end;
        r_offset <= n_offset;
        r_value  <= n_value;
        r_pkt    <= n_pkt;
        r_err    <= n_err;
    end

    assign o_out_valid = r_valid;
    assign o_offset    = r_offset;
    assign o_value     = r_value;
    assign o_last      = r_last;
    assign o_pkt       = r_pkt;
    assign o_err       = r_err;

    // a result that is not the last one is never at the final terminator step
    a_mid_in_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> r_step != STEP_CLASS_LO)
        else $error("non-last result at final terminator step");

    // packet size only rides on the last result
    a_pkt_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> r_pkt == '0)
        else $error("packet size on a non-last result");

    // terminator writes go to consecutive offsets
    a_term_consec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_step != STEP_LEN |-> r_offset == r_end + {6'd0, r_step})
        else $error("terminator write offset out of sequence");

    // no new item is taken while a terminator run is unfinished
    a_no_load_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |-> !o_free)
        else $error("input free during terminator run");

endmodule

/* rtl/dns_name_label_encoder.sv */
// dns_name_label_encoder: top level of the question-name label encoder
// depends on dnle_pkg, dnle_name_state and dnle_result_seq
//
// Takes a dotted domain name one character per transfer on the slave stream,
// a zero byte ending the name, and gives packet-buffer writes (offset, byte)
// on the master stream, placed after a 12-byte header. A character at name
// position i is written at offset 13+i; a dot writes the closed label's
// length into that label's length slot; the zero byte writes the last label
// length, a zero, the query type and the query class (high byte first) and
// reports the total packet size with its last write. Labels over 63
// characters and names over 255 characters set the sticky error flag in
// tuser; characters past 255 are dropped without a write. Rate: one transfer
// per clock for ordinary characters and dots while the master stream is
// ready; a terminator holds the input while its six writes leave the output
// register. The input is taken whenever the output register is empty or its
// last write of the current item is transferring in the same cycle.
// The first write of each item is computed in one pass from the name state
// registers and the character, and loaded into the output register.
// query_type and query_class reset to 1; the user must write them on the plain
// config port (index 0 and 1) only while idle; the block does not enforce it.
module dns_name_label_encoder
    import dnle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // character stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    // packet write stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [8:0] write_offset, [16:9] byte_value,
                                        // [25:17] packet_bytes, [31:26] zero
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // [0] label_error
);

    logic [15:0] r_query_type;
    logic [15:0] r_query_class;

    logic             in_xfer;
    logic             seq_free;
    t_first           first;
    logic [OFS_W-1:0] out_offset;
    logic [7:0]       out_value;
    logic [OFS_W-1:0] out_pkt;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_type  <= 16'd1;
            r_query_class <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUERY_TYPE:  r_query_type  <= i_cfg_data;
                CFG_QUERY_CLASS: r_query_class <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = seq_free;
    assign in_xfer       = s_axis_tvalid & seq_free;

    // name position, label slot and error state
    dnle_name_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_char   (s_axis_tdata),
        .o_first  (first)
    );

    // output register and terminator sequence
    dnle_result_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (in_xfer),
        .i_first       (first),
        .i_query_type  (r_query_type),
        .i_query_class (r_query_class),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_free        (seq_free),
        .o_offset      (out_offset),
        .o_value       (out_value),
        .o_last        (m_axis_tlast),
        .o_pkt         (out_pkt),
        .o_err         (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, out_pkt, out_value, out_offset};

endmodule

/* tb/tb.sv */
// tb: self-checking bench for dns_name_label_encoder, streams names in and checks
// every packet write against a cycle-free predictor of the label encoding
// depends on dnle_pkg and the dns_name_label_encoder rtl
`timescale 1ns / 1ps

module tb;
    import dnle_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int DRAIN_GAP   = 16;    // settle time once nothing is expected

    // one packet-buffer write as seen on the master stream
    typedef struct {
        logic [8:0] ofs;
        logic [7:0] value;
        logic       last;
        logic [8:0] total;
        logic       err;
    } t_pkt_write;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_QUERY_TYPE;
    logic [15:0] i_cfg_data    = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;     // [7:0] char_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;              // [8:0] write_offset, [16:9] byte_value,
                                            // [25:17] packet_bytes, [31:26] zero
    logic        m_axis_tlast;              // run_last
    logic        m_axis_tuser;              // [0] label_error

    dns_name_label_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // characters still to be sent and writes still to come back
    logic [7:0] char_queue[$];
    t_pkt_write write_queue[$];

    int send_idle_pct = 8;
    int recv_idle_pct = 87;
    int items_queued  = 0;
    int mismatch_count = 0;
    int quiet_cycles  = 0;

    // predictor copy of the name state and the question registers
    logic [7:0]  name_pos   = 8'd0;
    logic [7:0]  label_slot = 8'd0;
    logic [7:0]  label_len  = 8'd0;
    logic        name_err   = 1'b0;
    logic [15:0] qtype      = 16'd1;
    logic [15:0] qclass     = 16'd1;

    function automatic void add_write(logic [8:0] ofs, logic [7:0] value, logic last,
                                      logic [8:0] total, logic err);
        t_pkt_write w;
        w.ofs   = ofs;
        w.value = value;
        w.last  = last;
        w.total = total;
        w.err   = err;
        write_queue.push_back(w);
    endfunction

    // expected writes for one accepted character
    function automatic void encode_char(logic [7:0] ch);
        logic [8:0] name_end;
        if (ch == END_CHAR) begin
            // last length, zero root label, then type and class high byte first
            name_end = HEADER_BYTES + name_pos;
            add_write(HEADER_BYTES + label_slot, label_len, 1'b0, 9'd0, name_err);
            add_write(name_end + 9'd1, 8'd0, 1'b0, 9'd0, name_err);
            add_write(name_end + 9'd2, qtype[15:8], 1'b0, 9'd0, name_err);
            add_write(name_end + 9'd3, qtype[7:0], 1'b0, 9'd0, name_err);
            add_write(name_end + 9'd4, qclass[15:8], 1'b0, 9'd0, name_err);
            add_write(name_end + 9'd5, qclass[7:0], 1'b1, name_end + 9'd6, name_err);
            name_pos   = 8'd0;
            label_slot = 8'd0;
            label_len  = 8'd0;
            name_err   = 1'b0;
        end else if ({1'b0, name_pos} >= MAX_NAME) begin
            // name full: dropped, only the sticky error moves
            name_err = 1'b1;
        end else if (ch == DOT_CHAR) begin
            add_write(HEADER_BYTES + label_slot, label_len, 1'b1, 9'd0, name_err);
            label_slot = name_pos + 8'd1;
            label_len  = 8'd0;
            name_pos   = name_pos + 8'd1;
        end else begin
            if (label_len != 8'hFF)
                label_len = label_len + 8'd1;
            if (label_len > MAX_LABEL)
                name_err = 1'b1;
            add_write(HEADER_BYTES + name_pos + 9'd1, ch, 1'b1, 9'd0, name_err);
            name_pos = name_pos + 8'd1;
        end
    endfunction

    function automatic void check_field(string field, logic [8:0] want, logic [8:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers, all of them only fill char_queue and its item count
    // ---------------------------------------------------------------
    function automatic void push_char(logic [7:0] ch);
        char_queue.push_back(ch);
        items_queued++;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
        push_char(END_CHAR);
    endfunction

    // label of random non-separator characters
    function automatic void queue_label(int len);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            do
                ch = 8'($urandom_range(1, 255));
            while (ch == DOT_CHAR);
            push_char(ch);
        end
    endfunction

    // well-formed names mostly, with bursts of raw bytes mixed in
    function automatic void queue_random(int count);
        int start;
        int labels;
        int pick;
        start = items_queued;
        while (items_queued - start < count) begin
            if ($urandom_range(0, 9) < 7) begin
                labels = $urandom_range(1, 4);
                for (int l = 0; l < labels; l++) begin
                    // empty labels now and then
                    queue_label($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12));
                    if (l < labels - 1 || $urandom_range(0, 9) == 0)
                        push_char(DOT_CHAR);
                end
                push_char(END_CHAR);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3)
                        push_char(END_CHAR);
                    else if (pick < 5)
                        push_char(DOT_CHAR);
                    else
                        push_char(8'($urandom_range(0, 255)));
                end
            end
        end
        // leave the phase at a name boundary
        push_char(END_CHAR);
    endfunction

    // sender holds off until every expected write is back
    task automatic wait_idle();
        while (char_queue.size() != 0 || s_axis_tvalid || write_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // both registers, only while idle
    task automatic set_queries(logic [15:0] new_type, logic [15:0] new_class);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_QUERY_TYPE;
        i_cfg_data  <= new_type;
        @(posedge i_clk);
        i_cfg_index <= CFG_QUERY_CLASS;
        i_cfg_data  <= new_class;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        qtype  = new_type;
        qclass = new_class;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed names with the registers at their reset value
        queue_text("www.ab");
        queue_text("");
        // leading dot, two dots in a row, trailing dot
        push_char(DOT_CHAR);
        push_char(DOT_CHAR);
        push_char(8'hFF);
        push_char(DOT_CHAR);
        push_char(END_CHAR);
        // bit extremes of the character
        push_char(8'h01);
        push_char(8'h80);
        push_char(8'h7F);
        push_char(8'hFE);
        push_char(END_CHAR);
        wait_idle();

        // phase 1: sender rarely idle, receiver mostly stalled
        set_queries(16'hFFFF, 16'h0000);
        queue_random(20);
        // pause mid-phase until the output side runs dry
        wait_idle();
        // label of exactly 63 closes clean, the next one of 64 flags
        queue_label(63);
        push_char(DOT_CHAR);
        queue_label(64);
        push_char(END_CHAR);
        wait_idle();

        // phase 2: sender mostly idle, receiver rarely stalled
        send_idle_pct = 87;
        recv_idle_pct = 8;
        set_queries(16'h0000, 16'hFFFF);
        queue_random(22);
        wait_idle();

        // phase 3: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_queries(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        queue_random(22);
        wait_idle();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // driver: slave stream, one character per transfer
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                encode_char(s_axis_tdata);
            // hold the item until it is taken, else maybe idle
            if (!s_axis_tvalid || s_axis_tready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tdata  <= char_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: master stream, each write against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_pkt_write want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (write_queue.size() == 0) begin
                mismatch_count++;
                $error("write with nothing expected: offset %0d, byte %0d",
                       m_axis_tdata[8:0], m_axis_tdata[16:9]);
            end else begin
                want = write_queue.pop_front();
                check_field("write_offset", want.ofs, m_axis_tdata[8:0]);
                check_field("byte_value", {1'b0, want.value}, {1'b0, m_axis_tdata[16:9]});
                check_field("packet_bytes", want.total, m_axis_tdata[25:17]);
                check_field("tdata pad", 9'd0, {3'd0, m_axis_tdata[31:26]});
                check_field("run_last", {8'd0, want.last}, {8'd0, m_axis_tlast});
                check_field("label_error", {8'd0, want.err}, {8'd0, m_axis_tuser});
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: ends the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

/* sim.f */
rtl/dnle_pkg.sv
rtl/dnle_name_state.sv
rtl/dnle_result_seq.sv
rtl/dns_name_label_encoder.sv
tb/tb.sv
